@@ src/dwc_pkg.sv @@
// Shared widths, register indexes, status codes and reset values for the
// display window chunker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dwc_pkg;

    // field widths
    localparam int COORD_W  = 10;
    localparam int POS_W    = 11;
    localparam int BYTES_W  = 16;
    localparam int OFFS_W   = 19;
    localparam int STATUS_W = 2;
    localparam int PANEL_W  = 8;
    localparam int TW_W     = 12;   // twice the window width
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_XFER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_OFS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_COLS  = 2'd2;

    // reset values
    localparam logic [BYTES_W-1:0] MAX_XFER_RST  = 16'd28800;
    localparam logic [PANEL_W-1:0] PANEL_OFS_RST = 8'd20;
    localparam logic               OFS_COLS_RST  = 1'b0;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MANY = 2'd2;

    // default band limit
    localparam int MAX_BANDS_DEF = 6;

endpackage

`default_nettype wire

@@ src/display_window_chunker.sv @@
// Display window chunker: splits an offset window into row bands that fit
// one transfer. The first result is registered after a 16-step serial divider
// and a limit check; a reversed window skips both. Then one band per cycle as
// the output is taken. Configuration writes are taken in every cycle.
// Reset: async active low, configuration registers return to 28800 bytes,
// offset 20, rows.
`timescale 1ns / 1ps
`default_nettype none

module display_window_chunker
    import dwc_pkg::*;
#(
    parameter int MAX_BANDS = MAX_BANDS_DEF
) (
    input  wire                   clk,
    input  wire                   rst_n,
    // configuration write channel
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data,
    // window input channel
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  [COORD_W-1:0]    col_first,
    input  wire  [COORD_W-1:0]    col_last,
    input  wire  [COORD_W-1:0]    row_first,
    input  wire  [COORD_W-1:0]    row_last,
    // band result channel
    output logic                  out_valid,
    input  wire                   out_ready,
    output logic [POS_W-1:0]      band_col_start,
    output logic [POS_W-1:0]      band_col_end,
    output logic [POS_W-1:0]      band_row_start,
    output logic [POS_W-1:0]      band_row_end,
    output logic [BYTES_W-1:0]    band_bytes,
    output logic [OFFS_W-1:0]     band_offset,
    output logic [STATUS_W-1:0]   status,
    output logic                  last
);

    localparam int BANDS_W = $clog2(MAX_BANDS + 1);
    localparam int LIM_W   = BYTES_W + BANDS_W;
    localparam int CNT_W   = $clog2(BYTES_W);
    localparam int MUL_W   = POS_W + TW_W;

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_ERR  = 3'd4;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BYTES_W - 1);

    // configuration registers
    logic [BYTES_W-1:0]  max_xfer_reg;
    logic [PANEL_W-1:0]  panel_ofs_reg;
    logic                ofs_cols_reg;

    // control state
    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    // window working registers
    logic [POS_W-1:0]    cs_reg, cs_next;
    logic [POS_W-1:0]    ce_reg, ce_next;
    logic [POS_W-1:0]    rs_reg, rs_next;
    logic [POS_W-1:0]    left_reg, left_next;
    logic [TW_W-1:0]     tw_reg, tw_next;
    logic [OFFS_W-1:0]   offs_reg, offs_next;
    logic [STATUS_W-1:0] err_reg, err_next;

    // divider registers
    logic [TW_W-1:0]     div_rem_reg, div_rem_next;
    logic [BYTES_W-1:0]  div_quo_reg, div_quo_next;

    // output registers
    logic [POS_W-1:0]    o_cs_reg, o_cs_next;
    logic [POS_W-1:0]    o_ce_reg, o_ce_next;
    logic [POS_W-1:0]    o_rs_reg, o_rs_next;
    logic [POS_W-1:0]    o_re_reg, o_re_next;
    logic [BYTES_W-1:0]  o_bytes_reg, o_bytes_next;
    logic [OFFS_W-1:0]   o_offs_reg, o_offs_next;
    logic [STATUS_W-1:0] o_status_reg, o_status_next;
    logic                o_last_reg, o_last_next;

    logic                in_fire;
    logic                out_free;
    logic                reversed;
    logic [POS_W-1:0]    width;
    logic [POS_W-1:0]    height;
    logic [POS_W-1:0]    ofs_ext;
    logic [TW_W:0]       trial;
    logic                trial_ge;
    logic [LIM_W-1:0]    band_limit;
    logic                too_many;
    logic                final_band;
    logic [POS_W-1:0]    rows;
    logic [MUL_W-1:0]    prod;
    logic [BYTES_W-1:0]  bytes;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // configuration register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_xfer_reg  <= MAX_XFER_RST;
            panel_ofs_reg <= PANEL_OFS_RST;
            ofs_cols_reg  <= OFS_COLS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MAX_XFER:  max_xfer_reg  <= cfg_data;
                REG_PANEL_OFS: panel_ofs_reg <= cfg_data[PANEL_W-1:0];
                REG_OFS_COLS:  ofs_cols_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // window geometry at input
    assign reversed = (col_last < col_first) || (row_last < row_first);
    assign width    = POS_W'(col_last) - POS_W'(col_first) + POS_W'(1);
    assign height   = POS_W'(row_last) - POS_W'(row_first) + POS_W'(1);
    assign ofs_ext  = POS_W'(panel_ofs_reg);

    // one restoring division step
    assign trial    = {div_rem_reg, div_quo_reg[BYTES_W-1]};
    assign trial_ge = trial >= {1'b0, tw_reg};

    // band count limit check on the quotient
    assign band_limit = LIM_W'(div_quo_reg) * LIM_W'(MAX_BANDS);
    assign too_many   = LIM_W'(left_reg) > band_limit;

    // current band size
    assign final_band = BYTES_W'(left_reg) <= div_quo_reg;
    assign rows       = final_band ? left_reg : div_quo_reg[POS_W-1:0];
    assign prod       = MUL_W'(rows) * MUL_W'(tw_reg);
    assign bytes      = prod[BYTES_W-1:0];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cs_next        = cs_reg;
        ce_next        = ce_reg;
        rs_next        = rs_reg;
        left_next      = left_reg;
        tw_next        = tw_reg;
        offs_next      = offs_reg;
        err_next       = err_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        o_cs_next      = o_cs_reg;
        o_ce_next      = o_ce_reg;
        o_rs_next      = o_rs_reg;
        o_re_next      = o_re_reg;
        o_bytes_next   = o_bytes_reg;
        o_offs_next    = o_offs_reg;
        o_status_next  = o_status_reg;
        o_last_next    = o_last_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cs_next      = POS_W'(col_first) + (ofs_cols_reg ? ofs_ext : '0);
                    ce_next      = POS_W'(col_last) + (ofs_cols_reg ? ofs_ext : '0);
                    rs_next      = POS_W'(row_first) + (ofs_cols_reg ? '0 : ofs_ext);
                    left_next    = height;
                    tw_next      = {width, 1'b0};
                    offs_next    = '0;
                    div_rem_next = '0;
                    div_quo_next = max_xfer_reg;
                    cnt_next     = '0;
                    if (reversed)
                    begin
                        err_next   = ST_BAD;
                        state_next = S_ERR;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                div_rem_next = trial_ge ? TW_W'(trial - {1'b0, tw_reg}) : trial[TW_W-1:0];
                div_quo_next = {div_quo_reg[BYTES_W-2:0], trial_ge};
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (div_quo_reg == '0)
                begin
                    err_next   = ST_BAD;
                    state_next = S_ERR;
                end
                else if (too_many)
                begin
                    err_next   = ST_MANY;
                    state_next = S_ERR;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_cs_next      = cs_reg;
                    o_ce_next      = ce_reg;
                    o_rs_next      = rs_reg;
                    o_re_next      = rs_reg + rows - POS_W'(1);
                    o_bytes_next   = bytes;
                    o_offs_next    = offs_reg;
                    o_status_next  = ST_OK;
                    o_last_next    = final_band;
                    rs_next        = rs_reg + rows;
                    left_next      = left_reg - rows;
                    offs_next      = offs_reg + OFFS_W'(bytes);
                    if (final_band)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_cs_next      = '0;
                    o_ce_next      = '0;
                    o_rs_next      = '0;
                    o_re_next      = '0;
                    o_bytes_next   = '0;
                    o_offs_next    = '0;
                    o_status_next  = err_reg;
                    o_last_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cs_reg       <= cs_next;
        ce_reg       <= ce_next;
        rs_reg       <= rs_next;
        left_reg     <= left_next;
        tw_reg       <= tw_next;
        offs_reg     <= offs_next;
        err_reg      <= err_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        o_cs_reg     <= o_cs_next;
        o_ce_reg     <= o_ce_next;
        o_rs_reg     <= o_rs_next;
        o_re_reg     <= o_re_next;
        o_bytes_reg  <= o_bytes_next;
        o_offs_reg   <= o_offs_next;
        o_status_reg <= o_status_next;
        o_last_reg   <= o_last_next;
    end

    // result outputs
    assign out_valid      = out_valid_reg;
    assign band_col_start = o_cs_reg;
    assign band_col_end   = o_ce_reg;
    assign band_row_start = o_rs_reg;
    assign band_row_end   = o_re_reg;
    assign band_bytes     = o_bytes_reg;
    assign band_offset    = o_offs_reg;
    assign status         = o_status_reg;
    assign last           = o_last_reg;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking bench for display_window_chunker: a directed table, then random
// windows over several register settings, checked against a band predictor.
// Depends on dwc_pkg and the display_window_chunker RTL.
`timescale 1ns / 1ps

module testbench;
    import dwc_pkg::*;

    localparam int BAND_LIMIT = MAX_BANDS_DEF;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 33;

    // one band result
    typedef struct packed {
        logic [POS_W-1:0]    cs;
        logic [POS_W-1:0]    ce;
        logic [POS_W-1:0]    rs;
        logic [POS_W-1:0]    re;
        logic [BYTES_W-1:0]  nbytes;
        logic [OFFS_W-1:0]   offs;
        logic [STATUS_W-1:0] st;
        logic                lst;
    } band_t;

    typedef enum logic {ROW_WIN, ROW_CFG} row_kind_t;

    // directed stimulus row: a window or a register write
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] dat;
        logic [COORD_W-1:0]    cf;
        logic [COORD_W-1:0]    cl;
        logic [COORD_W-1:0]    rf;
        logic [COORD_W-1:0]    rl;
        logic                  typed;
        band_t                 want;
    } row_t;

    localparam band_t NO_BAND = '0;
    localparam band_t BAD_BAND = '{11'd0, 11'd0, 11'd0, 11'd0, 16'd0, 19'd0, ST_BAD, 1'b1};
    localparam band_t MANY_BAND = '{11'd0, 11'd0, 11'd0, 11'd0, 16'd0, 19'd0, ST_MANY, 1'b1};

    localparam int DIR_N = 29;
    localparam row_t DIR_TAB [DIR_N] = '{
        // reset settings: 28800 bytes, offset 20 on rows
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1,
          '{11'd0, 11'd0, 11'd20, 11'd20, 16'd2, 19'd0, ST_OK, 1'b1}},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b1,
          '{11'd1023, 11'd1023, 11'd1043, 11'd1043, 16'd2, 19'd0, ST_OK, 1'b1}},
        // reversed windows
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd5, 10'd4, 10'd0, 10'd0, 1'b1, BAD_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd0, 10'd9, 10'd8, 1'b1, BAD_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 1'b1, BAD_BAND},
        // full-width row, then the whole screen which needs too many bands
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd1023, 10'd0, 10'd0, 1'b1,
          '{11'd0, 11'd1023, 11'd20, 11'd20, 16'd2048, 19'd0, ST_OK, 1'b1}},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd1023, 10'd0, 10'd1023, 1'b1, MANY_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd100, 10'd339, 10'd0, 10'd239, 1'b0, NO_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd7, 10'd3, 10'd900, 1'b0, NO_BAND},
        // three rows per band: exactly six bands, partial last band, seven bands
        '{ROW_CFG, REG_MAX_XFER, 16'd12, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, NO_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd1, 10'd0, 10'd17, 1'b0, NO_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd1, 10'd0, 10'd16, 1'b0, NO_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd1, 10'd0, 10'd18, 1'b1, MANY_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd6, 10'd0, 10'd0, 1'b1, BAD_BAND},
        // smallest usable transfer: one pixel per band
        '{ROW_CFG, REG_MAX_XFER, 16'd2, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, NO_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd7, 10'd7, 10'd0, 10'd5, 1'b0, NO_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd7, 10'd8, 10'd0, 10'd0, 1'b1, BAD_BAND},
        // transfer too small for any pixel
        '{ROW_CFG, REG_MAX_XFER, 16'd1, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, NO_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd3, 10'd3, 10'd3, 10'd3, 1'b1, BAD_BAND},
        '{ROW_CFG, REG_MAX_XFER, 16'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, NO_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd0, 10'd0, 10'd0, 1'b1, BAD_BAND},
        // all ones written: largest transfer, offset 255 on columns
        '{ROW_CFG, REG_MAX_XFER, 16'hFFFF, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, NO_BAND},
        '{ROW_CFG, REG_PANEL_OFS, 16'hFFFF, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, NO_BAND},
        '{ROW_CFG, REG_OFS_COLS, 16'hFFFF, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, NO_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd1023, 10'd1023, 10'd0, 10'd0, 1'b1,
          '{11'd1278, 11'd1278, 11'd0, 11'd0, 16'd2, 19'd0, ST_OK, 1'b1}},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd1023, 10'd0, 10'd1023, 1'b1, MANY_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd0, 10'd1023, 10'd0, 10'd185, 1'b0, NO_BAND},
        // write to an unmapped index changes nothing
        '{ROW_CFG, REG_UNUSED, 16'h1234, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, NO_BAND},
        '{ROW_WIN, REG_MAX_XFER, 16'd0, 10'd10, 10'd20, 10'd30, 10'd40, 1'b0, NO_BAND}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [COORD_W-1:0]    col_first = '0;
    logic [COORD_W-1:0]    col_last = '0;
    logic [COORD_W-1:0]    row_first = '0;
    logic [COORD_W-1:0]    row_last = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [POS_W-1:0]      band_col_start;
    logic [POS_W-1:0]      band_col_end;
    logic [POS_W-1:0]      band_row_start;
    logic [POS_W-1:0]      band_row_end;
    logic [BYTES_W-1:0]    band_bytes;
    logic [OFFS_W-1:0]     band_offset;
    logic [STATUS_W-1:0]   status;
    logic                  last;

    // register copies used by the predictor
    logic [BYTES_W-1:0]    xfer_max = MAX_XFER_RST;
    logic [PANEL_W-1:0]    panel_ofs = PANEL_OFS_RST;
    logic                  ofs_cols = OFS_COLS_RST;

    band_t band_q[$];
    int    err_cnt = 0;
    int    tx_gap_pct = 20;
    int    rx_stall_pct = 20;
    int    rx_stall_left = 0;
    band_t got_band;
    band_t want_band;

    display_window_chunker #(
        .MAX_BANDS(BAND_LIMIT)
    ) u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .col_first      (col_first),
        .col_last       (col_last),
        .row_first      (row_first),
        .row_last       (row_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .band_col_start (band_col_start),
        .band_col_end   (band_col_end),
        .band_row_start (band_row_start),
        .band_row_end   (band_row_end),
        .band_bytes     (band_bytes),
        .band_offset    (band_offset),
        .status         (status),
        .last           (last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    // split one window into the bands the block should emit
    function automatic void chunk_window(input logic [COORD_W-1:0] cf_in,
                                         input logic [COORD_W-1:0] cl_in,
                                         input logic [COORD_W-1:0] rf_in,
                                         input logic [COORD_W-1:0] rl_in);
        int cf, cl, rf, rl, mx, w, lines, h, full, rem, total, bsz, i;
        band_t b;
        cf = cf_in;
        cl = cl_in;
        rf = rf_in;
        rl = rl_in;
        mx = xfer_max;
        b = '0;
        b.lst = 1'b1;
        if (cl < cf || rl < rf) begin
            b.st = ST_BAD;
            band_q.push_back(b);
            return;
        end
        if (ofs_cols) begin
            cf += panel_ofs;
            cl += panel_ofs;
        end
        else begin
            rf += panel_ofs;
            rl += panel_ofs;
        end
        w = cl - cf + 1;
        lines = mx / (2 * w);
        if (lines == 0) begin
            b.st = ST_BAD;
            band_q.push_back(b);
            return;
        end
        h = rl - rf + 1;
        full = h / lines;
        rem = h % lines;
        total = full + ((rem > 0) ? 1 : 0);
        if (total > BAND_LIMIT) begin
            b.st = ST_MANY;
            band_q.push_back(b);
            return;
        end
        bsz = w * lines * 2;
        for (i = 0; i < total; i++) begin
            b.cs = POS_W'(cf);
            b.ce = POS_W'(cl);
            b.rs = POS_W'(rf + i * lines);
            b.re = (i < full) ? POS_W'(rf + i * lines + lines - 1) : POS_W'(rl);
            b.nbytes = (i < full) ? BYTES_W'(bsz) : BYTES_W'(rem * w * 2);
            b.offs = OFFS_W'(i * bsz);
            b.st = ST_OK;
            b.lst = (i + 1 == total);
            band_q.push_back(b);
        end
    endfunction

    // drop valid and hold it low for the requested pause
    task automatic pause_input(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // hold off until every expected band has come back
    task automatic drain_bands();
        @(negedge clk);
        in_valid <= 1'b0;
        while (band_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] dat);
        drain_bands();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= dat;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MAX_XFER:  xfer_max = dat;
            REG_PANEL_OFS: panel_ofs = dat[PANEL_W-1:0];
            REG_OFS_COLS:  ofs_cols = dat[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // all three registers, junk in the unused upper bits
    task automatic set_phase(input logic [BYTES_W-1:0] mx, input logic [PANEL_W-1:0] ofs,
                             input logic cols);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_MAX_XFER, mx);
        write_reg(REG_PANEL_OFS, {junk[15:8], ofs});
        write_reg(REG_OFS_COLS, {junk[15:1], cols});
    endtask

    // one window transaction; the expectation is queued on acceptance
    task automatic send_window(input logic [COORD_W-1:0] cf, input logic [COORD_W-1:0] cl,
                               input logic [COORD_W-1:0] rf, input logic [COORD_W-1:0] rl,
                               input logic typed, input band_t want);
        @(negedge clk);
        in_valid <= 1'b1;
        col_first <= cf;
        col_last <= cl;
        row_first <= rf;
        row_last <= rl;
        do @(posedge clk); while (!in_ready);
        if (typed)
            band_q.push_back(want);
        else
            chunk_window(cf, cl, rf, rl);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct)
            pause_input($urandom_range(1, 12));
    endtask

    // result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
            rx_stall_left <= $urandom_range(0, 11);
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // compare each band transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            got_band = '{band_col_start, band_col_end, band_row_start, band_row_end,
                         band_bytes, band_offset, status, last};
            if (band_q.size() == 0) begin
                report_mismatch("band result with no window pending");
            end
            else begin
                want_band = band_q.pop_front();
                if (got_band.cs !== want_band.cs)
                    report_mismatch($sformatf("band_col_start got %0d expected %0d",
                                              got_band.cs, want_band.cs));
                if (got_band.ce !== want_band.ce)
                    report_mismatch($sformatf("band_col_end got %0d expected %0d",
                                              got_band.ce, want_band.ce));
                if (got_band.rs !== want_band.rs)
                    report_mismatch($sformatf("band_row_start got %0d expected %0d",
                                              got_band.rs, want_band.rs));
                if (got_band.re !== want_band.re)
                    report_mismatch($sformatf("band_row_end got %0d expected %0d",
                                              got_band.re, want_band.re));
                if (got_band.nbytes !== want_band.nbytes)
                    report_mismatch($sformatf("band_bytes got %0d expected %0d",
                                              got_band.nbytes, want_band.nbytes));
                if (got_band.offs !== want_band.offs)
                    report_mismatch($sformatf("band_offset got %0d expected %0d",
                                              got_band.offs, want_band.offs));
                if (got_band.st !== want_band.st)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              got_band.st, want_band.st));
                if (got_band.lst !== want_band.lst)
                    report_mismatch($sformatf("last got %0d expected %0d",
                                              got_band.lst, want_band.lst));
            end
        end
    end

    // stimulus
    initial
    begin : stim
        int i, p, k, mx, w, wcap, lines, nb, lo, hi, h;
        logic [COORD_W-1:0] cf, cl, rf, rl;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (i = 0; i < DIR_N; i++) begin
            if (DIR_TAB[i].kind == ROW_CFG)
                write_reg(DIR_TAB[i].idx, DIR_TAB[i].dat);
            else
                send_window(DIR_TAB[i].cf, DIR_TAB[i].cl, DIR_TAB[i].rf, DIR_TAB[i].rl,
                            DIR_TAB[i].typed, DIR_TAB[i].want);
        end

        // random windows over several register settings
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    set_phase(MAX_XFER_RST, PANEL_OFS_RST, OFS_COLS_RST);
                    tx_gap_pct = 20;
                    rx_stall_pct = 20;
                end
                1: begin
                    set_phase(16'hFFFF, 8'hFF, 1'b1);
                    tx_gap_pct = 0;
                    rx_stall_pct = 0;
                end
                2: begin
                    set_phase(16'd2, 8'd0, 1'b0);
                    tx_gap_pct = 30;
                    rx_stall_pct = 30;
                end
                4: begin
                    set_phase(16'd4096, 8'd128, 1'b0);
                    tx_gap_pct = 40;
                    rx_stall_pct = 10;
                end
                default: begin
                    set_phase(BYTES_W'($urandom_range(64, 8192)),
                              PANEL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    // the closing phase runs with no idling at all
                    tx_gap_pct = (p == PHASES - 1) ? 0 : 10;
                    rx_stall_pct = (p == PHASES - 1) ? 0 : 40;
                end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (k == 15)
                    drain_bands();
                if ($urandom_range(0, 99) < 80) begin
                    // well-formed window sized for one to six bands
                    mx = xfer_max;
                    wcap = mx / 2;
                    if (wcap < 1)
                        wcap = 1;
                    if (wcap > 1024)
                        wcap = 1024;
                    if ($urandom_range(0, 3) == 0)
                        w = $urandom_range(1, wcap);
                    else
                        w = $urandom_range(1, (wcap < 64) ? wcap : 64);
                    cf = COORD_W'($urandom_range(0, 1024 - w));
                    cl = COORD_W'(cf + w - 1);
                    lines = mx / (2 * w);
                    if (lines < 1)
                        lines = 1;
                    nb = $urandom_range(1, BAND_LIMIT);
                    hi = nb * lines;
                    lo = (nb - 1) * lines + 1;
                    if (hi > 1024)
                        hi = 1024;
                    if (lo > hi)
                        lo = hi;
                    h = $urandom_range(lo, hi);
                    rf = COORD_W'($urandom_range(0, 1024 - h));
                    rl = COORD_W'(rf + h - 1);
                end
                else begin
                    // noise: reversed, too wide, too tall
                    cf = COORD_W'($urandom);
                    cl = COORD_W'($urandom);
                    rf = COORD_W'($urandom);
                    rl = COORD_W'($urandom);
                end
                send_window(cf, cl, rf, rl, 1'b0, NO_BAND);
            end
        end

        drain_bands();
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/dwc_pkg.sv
src/display_window_chunker.sv
tb/sv/testbench.sv
